// File: sv/dsbb_pkg.sv
// Shared types, constants and helper functions for the dab stroke bounding box.
// No dependencies; every module of the block imports this package.
package dsbb_pkg;

    localparam int POS_W       = 40;   // current position, 1/512 px or px
    localparam int SUB_SHIFT   = 7;    // quarter pixel -> 1/512 pixel
    localparam int SIZE_SHIFT  = 8;    // size/256 -> whole pixels
    localparam int CORNER_W    = 34;   // corner math before saturation

    localparam logic signed [31:0] EMPTY_LOW  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] EMPTY_HIGH = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_START_SUB = 2'd0,
        CMD_START_PIX = 2'd1,
        CMD_DAB       = 2'd2
    } dsbb_cmd_t;

    typedef enum logic [1:0] {
        BOX_KEEP  = 2'd0,
        BOX_SET   = 2'd1,
        BOX_WIDEN = 2'd2
    } dsbb_box_op_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        brush_size;
        logic [15:0]        layer;
        logic               indirect;
        logic               last;
    } dsbb_item_t;

    typedef struct packed {
        logic               domain;
        logic [15:0]        layer_out;
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
    } dsbb_result_t;

    // beat handed from the position stage to the box stage
    typedef struct packed {
        logic               valid;
        dsbb_box_op_t       op;
        logic               last;
        logic               indirect;
        logic [15:0]        layer;
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
    } dsbb_stage_t;

    function automatic logic signed [31:0] sat32(input logic signed [CORNER_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(CORNER_W-32){1'b0}}, EMPTY_LOW}))
            r = EMPTY_LOW;
        else if (v < $signed({{(CORNER_W-32){1'b1}}, EMPTY_HIGH}))
            r = EMPTY_HIGH;
        else
            r = v[31:0];
        return r;
    endfunction

    // signed divide by 512, rounding toward zero
    function automatic logic signed [31:0] div512_trunc(input logic signed [POS_W:0] v);
        logic [31:0] q;
        q = v[POS_W:9];
        if (v[POS_W] && (v[8:0] != 9'd0))
            q = q + 32'd1;
        return $signed(q);
    endfunction

    // signed divide by 4, rounding toward zero
    function automatic logic signed [31:0] div4_trunc(input logic signed [31:0] v);
        logic [31:0] q;
        q = {{2{v[31]}}, v[31:2]};
        if (v[31] && (v[1:0] != 2'd0))
            q = q + 32'd1;
        return $signed(q);
    endfunction

endpackage

// File: sv/dab_stroke_bounding_box.sv
// A result moves through the input register, then the position stage, then
// the box/result register, and is valid once its last beat has reached that register.
// Throughput: one beat per cycle; ready drops only while a finished result
// waits unread, a last beat is held in the position stage behind it and the
// input register is occupied.
// Reset (rst_n, async, active low) clears the pipeline, pen position, mode,
// layer and box to zero.
module dab_stroke_bounding_box (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  dsbb_pkg::dsbb_item_t   item_data,
    output logic                   box_valid,
    input  logic                   box_ready,
    output dsbb_pkg::dsbb_result_t box_data
);
    import dsbb_pkg::*;

    logic        a_valid_reg;
    dsbb_item_t  a_item_reg;
    dsbb_stage_t stage;
    logic        b_stall;
    logic        advance;

    assign advance    = !(stage.valid && b_stall);
    assign item_ready = !a_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (item_ready)
            a_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            a_item_reg <= item_data;
    end

    dsbb_pos_stage u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid_reg),
        .a_item  (a_item_reg),
        .advance (advance),
        .stage   (stage)
    );

    dsbb_box_stage u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .stall     (b_stall),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box_data  (box_data)
    );

    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (a_valid_reg && stage.valid && stage.last && box_valid))
        else $error("input stalled with room in the pipeline");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !advance) |=> (a_valid_reg && $stable(a_item_reg)))
        else $error("input register lost a stalled beat");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && !advance) |=> $stable(stage))
        else $error("position stage moved while stalled");

endmodule

// File: sv/dsbb_pos_stage.sv
// Position stage: stroke mode, layer and current pen position; computes each
// beat's box corners and registers them for the box stage. Uses dsbb_pkg.
module dsbb_pos_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                a_valid,
    input  dsbb_pkg::dsbb_item_t a_item,
    input  logic                advance,
    output dsbb_pkg::dsbb_stage_t stage
);
    import dsbb_pkg::*;

    logic                     pixel_mode_reg, pixel_mode_next;
    logic signed [POS_W-1:0]  cur_x_reg, cur_x_next;
    logic signed [POS_W-1:0]  cur_y_reg, cur_y_next;
    logic [15:0]              layer_reg, layer_next;
    logic                     indirect_reg, indirect_next;
    dsbb_stage_t              stage_reg, stage_next;

    logic signed [POS_W-1:0]  sub_x, sub_y;
    logic signed [POS_W:0]    sub_vx, sub_vy;
    logic signed [CORNER_W-1:0] sub_l, sub_t, sub_r, sub_b;
    logic [31:0]              pix_x, pix_y;
    logic [16:0]              half;
    logic signed [CORNER_W-1:0] pix_l, pix_t, pix_r, pix_b;
    logic signed [31:0]       start_x, start_y;

    // subpixel dab: move in 1/512 px, corner = trunc((cur - size) / 512)
    assign sub_x  = cur_x_reg + {a_item.pos_x[31], a_item.pos_x, {SUB_SHIFT{1'b0}}};
    assign sub_y  = cur_y_reg + {a_item.pos_y[31], a_item.pos_y, {SUB_SHIFT{1'b0}}};
    assign sub_vx = {sub_x[POS_W-1], sub_x} - $signed({{(POS_W-15){1'b0}}, a_item.brush_size});
    assign sub_vy = {sub_y[POS_W-1], sub_y} - $signed({{(POS_W-15){1'b0}}, a_item.brush_size});
    assign sub_l  = CORNER_W'(div512_trunc(sub_vx));
    assign sub_t  = CORNER_W'(div512_trunc(sub_vy));
    assign sub_r  = sub_l + $signed({{(CORNER_W-8){1'b0}}, a_item.brush_size[15:SIZE_SHIFT]});
    assign sub_b  = sub_t + $signed({{(CORNER_W-8){1'b0}}, a_item.brush_size[15:SIZE_SHIFT]});

    // pixel dab: 32-bit wrap, square of side size+1 centered by (size+1)/2
    assign pix_x = cur_x_reg[31:0] + a_item.pos_x;
    assign pix_y = cur_y_reg[31:0] + a_item.pos_y;
    assign half  = ({1'b0, a_item.brush_size} + 17'd1) >> 1;
    assign pix_l = $signed({{2{pix_x[31]}}, pix_x}) - $signed({17'd0, half});
    assign pix_t = $signed({{2{pix_y[31]}}, pix_y}) - $signed({17'd0, half});
    assign pix_r = pix_l + $signed({18'd0, a_item.brush_size});
    assign pix_b = pix_t + $signed({18'd0, a_item.brush_size});

    assign start_x = div4_trunc(a_item.pos_x);
    assign start_y = div4_trunc(a_item.pos_y);

    always_comb
    begin
        pixel_mode_next = pixel_mode_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        layer_next      = layer_reg;
        indirect_next   = indirect_reg;

        stage_next          = stage_reg;
        stage_next.valid    = a_valid;
        stage_next.op       = BOX_KEEP;
        stage_next.last     = a_item.last;
        stage_next.indirect = indirect_reg;
        stage_next.layer    = layer_reg;

        case (a_item.command)
            CMD_START_SUB:
            begin
                pixel_mode_next     = 1'b0;
                cur_x_next          = {a_item.pos_x[31], a_item.pos_x, {SUB_SHIFT{1'b0}}};
                cur_y_next          = {a_item.pos_y[31], a_item.pos_y, {SUB_SHIFT{1'b0}}};
                layer_next          = a_item.layer;
                indirect_next       = a_item.indirect;
                stage_next.op       = BOX_SET;
                stage_next.indirect = a_item.indirect;
                stage_next.layer    = a_item.layer;
                stage_next.left     = start_x;
                stage_next.right    = start_x;
                stage_next.top      = start_y;
                stage_next.bottom   = start_y;
            end
            CMD_START_PIX:
            begin
                pixel_mode_next     = 1'b1;
                cur_x_next          = {{(POS_W-32){a_item.pos_x[31]}}, a_item.pos_x};
                cur_y_next          = {{(POS_W-32){a_item.pos_y[31]}}, a_item.pos_y};
                layer_next          = a_item.layer;
                indirect_next       = a_item.indirect;
                stage_next.op       = BOX_SET;
                stage_next.indirect = a_item.indirect;
                stage_next.layer    = a_item.layer;
                stage_next.left     = a_item.pos_x;
                stage_next.right    = a_item.pos_x;
                stage_next.top      = a_item.pos_y;
                stage_next.bottom   = a_item.pos_y;
            end
            CMD_DAB:
            begin
                stage_next.op = BOX_WIDEN;
                if (pixel_mode_reg)
                begin
                    cur_x_next        = {{(POS_W-32){pix_x[31]}}, pix_x};
                    cur_y_next        = {{(POS_W-32){pix_y[31]}}, pix_y};
                    stage_next.left   = sat32(pix_l);
                    stage_next.top    = sat32(pix_t);
                    stage_next.right  = sat32(pix_r);
                    stage_next.bottom = sat32(pix_b);
                end
                else
                begin
                    cur_x_next        = sub_x;
                    cur_y_next        = sub_y;
                    stage_next.left   = sat32(sub_l);
                    stage_next.top    = sat32(sub_t);
                    stage_next.right  = sat32(sub_r);
                    stage_next.bottom = sat32(sub_b);
                end
            end
            default:
            begin
                stage_next.op = BOX_KEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            layer_reg      <= '0;
            indirect_reg   <= 1'b0;
            stage_reg      <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
            if (a_valid)
            begin
                pixel_mode_reg <= pixel_mode_next;
                cur_x_reg      <= cur_x_next;
                cur_y_reg      <= cur_y_next;
                layer_reg      <= layer_next;
                indirect_reg   <= indirect_next;
            end
        end
    end

    assign stage = stage_reg;

    // a dab square always has its high corner at or past its low corner
    a_widen_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && stage_reg.op == BOX_WIDEN) |->
        (stage_reg.left <= stage_reg.right && stage_reg.top <= stage_reg.bottom))
        else $error("dab corners out of order");

    // pen state only moves when a beat passes through
    a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!(advance && a_valid)) |-> ($stable(cur_x_reg) && $stable(cur_y_reg)))
        else $error("position changed without a beat");

    a_start_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg.valid && stage_reg.op == BOX_SET) |->
        (stage_reg.left == stage_reg.right && stage_reg.top == stage_reg.bottom))
        else $error("start beat does not seed a single pixel");

endmodule

// File: sv/dsbb_box_stage.sv
// Box stage: running min/max box of the stroke and the result register.
// Uses dsbb_pkg; fed by dsbb_pos_stage.
module dsbb_box_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsbb_pkg::dsbb_stage_t stage,
    output logic                  stall,
    output logic                  box_valid,
    input  logic                  box_ready,
    output dsbb_pkg::dsbb_result_t box_data
);
    import dsbb_pkg::*;

    logic signed [31:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [31:0] left_next, top_next, right_next, bottom_next;
    logic               out_valid_reg, out_valid_next;
    dsbb_result_t       out_reg, out_next;
    logic               fire;

    // only a last beat can be held back, and only by a full result register
    assign stall = stage.valid && stage.last && out_valid_reg && !box_ready;
    assign fire  = stage.valid && !stall;

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        case (stage.op)
            BOX_SET:
            begin
                left_next   = stage.left;
                top_next    = stage.top;
                right_next  = stage.right;
                bottom_next = stage.bottom;
            end
            BOX_WIDEN:
            begin
                if ($signed(stage.left) < left_reg)     left_next   = stage.left;
                if ($signed(stage.top) < top_reg)       top_next    = stage.top;
                if ($signed(stage.right) > right_reg)   right_next  = stage.right;
                if ($signed(stage.bottom) > bottom_reg) bottom_next = stage.bottom;
            end
            default:
            begin
                left_next = left_reg;
            end
        endcase

        if (stage.indirect)
        begin
            out_next.domain    = 1'b1;
            out_next.layer_out = '0;
            out_next.left      = EMPTY_LOW;
            out_next.top       = EMPTY_LOW;
            out_next.right     = EMPTY_HIGH;
            out_next.bottom    = EMPTY_HIGH;
        end
        else
        begin
            out_next.domain    = 1'b0;
            out_next.layer_out = stage.layer;
            out_next.left      = left_next;
            out_next.top       = top_next;
            out_next.right     = right_next;
            out_next.bottom    = bottom_next;
        end

        out_valid_next = out_valid_reg && !box_ready;
        if (fire && stage.last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            top_reg       <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                left_reg   <= left_next;
                top_reg    <= top_next;
                right_reg  <= right_next;
                bottom_reg <= bottom_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && stage.last)
            out_reg <= out_next;
    end

    assign box_valid = out_valid_reg;
    assign box_data  = out_reg;

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg <= right_reg) && (top_reg <= bottom_reg))
        else $error("running box out of order");

    a_indirect_result: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_data.domain) |->
        (box_data.layer_out == '0 && box_data.left == EMPTY_LOW &&
         box_data.right == EMPTY_HIGH))
        else $error("indirect result is not the empty box");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (box_valid && $stable(left_reg) && $stable(right_reg)) || !$past(stall))
        else $error("box moved while stalled");

endmodule
